/* src/biem_pkg.sv */
// ----------------------------------------------------------------------------
// biem_pkg: shared types and constants of the binary image edge marker
// Holds the configuration register codes, the result record that travels
// from the window pipeline through the result queue, and the queue sizing.
// ----------------------------------------------------------------------------
package biem_pkg;

	// Configuration port.
	localparam int CFG_DATA_W  = 11;
	localparam int CFG_INDEX_W = 1;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_IMAGE_WIDTH  = 1'b0,
		REG_IMAGE_HEIGHT = 1'b1
	} cfg_reg_t;

	// Frame size after reset, before clamping to the build limits.
	localparam int DIM_RESET_WIDTH  = 640;
	localparam int DIM_RESET_HEIGHT = 480;

	// Row and column fields of a result are reported in this many bits.
	localparam int COORD_W = 10;

	typedef struct packed {
		logic               edge_bit;
		logic [COORD_W-1:0] out_row;
		logic [COORD_W-1:0] out_col;
		logic               frame_last;
	} result_t;

	// Result queue.
	localparam int RQ_DEPTH = 4;
	localparam int RQ_PTR_W = $clog2(RQ_DEPTH);
	localparam int RQ_CNT_W = $clog2(RQ_DEPTH + 1);

	typedef struct packed {
		logic [RQ_CNT_W-1:0] count;
		logic                full;
		logic                empty;
	} rq_status_t;

endpackage

/* src/biem_ifs.sv */
// ----------------------------------------------------------------------------
// biem_ifs: stream channels of the binary image edge marker
// Pixel channel into the block and result channel out of it, each with
// valid/ready handshake and a source and a sink modport.
// ----------------------------------------------------------------------------
interface biem_pixel_if;
	logic valid;
	logic ready;
	logic command;
	logic pixel_bit;

	modport source (output valid, output command, output pixel_bit, input ready);
	modport sink   (input valid, input command, input pixel_bit, output ready);
endinterface

interface biem_result_if import biem_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               edge_bit;
	logic [COORD_W-1:0] out_row;
	logic [COORD_W-1:0] out_col;
	logic               frame_last;

	modport source (output valid, output edge_bit, output out_row, output out_col,
		output frame_last, input ready);
	modport sink   (input valid, input edge_bit, input out_row, input out_col,
		input frame_last, output ready);
endinterface

/* src/biem_result_queue.sv */
// ----------------------------------------------------------------------------
// biem_result_queue: small result queue at the output of the edge marker
// Decouples the fixed-latency window pipeline from a stalling receiver.
// The head entry is presented directly; status tells the producer how full.
// ----------------------------------------------------------------------------
module biem_result_queue import biem_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  result_t    push_data,
	input  logic       pop,
	output result_t    head,
	output rq_status_t stat
);

	result_t             entry_q [RQ_DEPTH];
	logic [RQ_PTR_W-1:0] wr_ptr_q;
	logic [RQ_PTR_W-1:0] rd_ptr_q;
	logic [RQ_CNT_W-1:0] count_q;
	logic                do_push;
	logic                do_pop;

	assign stat.count = count_q;
	assign stat.full  = (count_q == RQ_CNT_W'(RQ_DEPTH));
	assign stat.empty = (count_q == '0);
	assign head       = entry_q[rd_ptr_q];

	assign do_push = push && !stat.full;
	assign do_pop  = pop && !stat.empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

/* src/binary_image_edge_marker_core.sv */
// ----------------------------------------------------------------------------
// binary_image_edge_marker_core: marks embeddable edge pixels of a binary image
// Two 3x3 window stages over line memories, one pixel per clock while pixels.ready is high.
// ----------------------------------------------------------------------------
// Usage
//   Pixels arrive on the pixels channel in raster order, one per beat
//   (command 0). Every pixel beat yields the result for the pixel 2*W+2
//   places earlier in the frame; once the last pixel of a frame is in,
//   drain beats (command 1) push out the remaining 2*W+2 results, one each.
//   Drain beats during a frame or after the frame is fully drained do
//   nothing. A pixel beat after a complete frame starts the next frame.
//   Results leave on the results channel with row, column and a frame_last
//   flag on the final pixel of the frame.
//   A result triggered by an input beat passes the stage 1, stage 2 and
//   result queue registers before it is presented. Throughput is one beat
//   per cycle while pixels.ready is high; the source and mark line memories
//   each see one read and one write per pixel, which sets that rate.
//   cfg_wr_en writes image_width (index 0) or image_height (index 1); both
//   are clamped to 3..MAX. A write restarts the frame; it is to be made only
//   while the block is idle, which the block itself does not enforce.
//   Reset selects a 640 x 480 frame and clears all counters. The line
//   memories are not cleared: rows that would read stale entries are
//   border rows, which always give 0.
//   When the receiver stalls, results collect in a four-entry queue;
//   pixels.ready drops once the queue plus results in flight fill it.
// ----------------------------------------------------------------------------
module binary_image_edge_marker_core import biem_pkg::*; #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wr_en,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_wdata,
	biem_pixel_if.sink             pixels,
	biem_result_if.source          results
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);
	localparam int RST_W = (DIM_RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : DIM_RESET_WIDTH;
	localparam int RST_H = (DIM_RESET_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : DIM_RESET_HEIGHT;

	// Frame geometry, kept as last column and last row after clamping.
	logic [CW-1:0] last_col_q;
	logic [RW-1:0] last_row_q;

	// Input and output raster position.
	logic [CW-1:0] in_col_q;
	logic [RW-1:0] in_row_q;
	logic          frame_done_q;
	logic [CW-1:0] out_col_q;
	logic [RW-1:0] out_row_q;
	logic          out_done_q;

	// Line memories. Source entries hold the two rows above, mark entries
	// hold {source, mark} pairs of the two rows above.
	logic [1:0] src_mem  [MAX_WIDTH];
	logic [3:0] mark_mem [MAX_WIDTH];

	// Stage 1: source window and mark computation.
	logic          v_s1;
	logic          emit_s1;
	logic          pix_s1;
	logic [CW-1:0] col_s1;
	logic          inter_s1;
	result_t       res_s1;
	logic [1:0]    src_rd_s1;
	logic [2:0]    sw1_q;
	logic [2:0]    sw2_q;

	// Stage 2: mark window and edge decision.
	logic          v_s2;
	logic          emit_s2;
	logic [1:0]    pair_s2;
	logic [CW-1:0] col_s2;
	result_t       res_s2;
	logic [3:0]    mrd_s2;
	logic [5:0]    mw1_q;
	logic [5:0]    mw2_q;

	// Accept-side decode.
	logic          acc;
	logic          is_pix;
	logic          restart;
	logic          drain_emit;
	logic          issue;
	logic          emit;
	logic          interior;
	logic [CW-1:0] col_eff;
	logic [RW-1:0] row_eff;
	logic [CW-1:0] out_col_eff;
	logic [RW-1:0] out_row_eff;
	logic          out_last;
	logic [CW-1:0] col_nxt;
	logic [CW-1:0] cfg_last_col;
	logic [RW-1:0] cfg_last_row;

	// Window logic.
	logic [2:0]    col_v;
	logic          nb_l;
	logic          nb_r;
	logic          nb_t;
	logic          nb_b;
	logic [2:0]    nb_sum;
	logic          mark_c;
	logic [5:0]    col2_v;
	logic [17:0]   mwin;
	logic [3:0]    mark_sum;
	logic [3:0]    src_sum;
	logic          edge_c;

	// Output queue.
	result_t             push_data;
	result_t             head;
	rq_status_t          rq_stat;
	logic                push;
	logic                pop;
	logic [RQ_CNT_W-1:0] occ;

	function automatic logic [3:0] count_bits(input logic [17:0] win, input logic odd);
		logic [3:0] sum;
		sum = '0;
		for (int i = 0; i < 9; i++) begin
			sum = sum + {3'b000, win[2 * i + (odd ? 1 : 0)]};
		end
		return sum;
	endfunction

	// ------------------------------------------------------------------
	// Configuration values, clamped to the supported frame size.
	// ------------------------------------------------------------------
	always_comb begin
		if (cfg_wdata < CFG_DATA_W'(3)) begin
			cfg_last_col = CW'(2);
			cfg_last_row = RW'(2);
		end else begin
			cfg_last_col = (int'(cfg_wdata) > MAX_WIDTH) ? CW'(MAX_WIDTH - 1)
			                                             : CW'(cfg_wdata - 1'b1);
			cfg_last_row = (int'(cfg_wdata) > MAX_HEIGHT) ? RW'(MAX_HEIGHT - 1)
			                                              : RW'(cfg_wdata - 1'b1);
		end
	end

	// ------------------------------------------------------------------
	// Beat decode. A pixel after a finished frame restarts the position
	// counters, so it is placed at row 0, column 0. A drain beat only
	// enters the pipeline while results of a finished frame remain; it
	// then behaves as a zero pixel past the frame end and keeps the
	// column count running so the line memories stay aligned.
	// ------------------------------------------------------------------
	assign acc        = pixels.valid && pixels.ready;
	assign is_pix     = !pixels.command;
	assign restart    = is_pix && frame_done_q;
	assign drain_emit = frame_done_q && !out_done_q;
	assign issue      = acc && (is_pix || drain_emit);

	assign col_eff     = restart ? '0 : in_col_q;
	assign row_eff     = restart ? '0 : in_row_q;
	assign out_col_eff = restart ? '0 : out_col_q;
	assign out_row_eff = restart ? '0 : out_row_q;
	assign out_last    = (out_row_eff == last_row_q) && (out_col_eff == last_col_q);
	assign col_nxt     = (col_eff == last_col_q) ? '0 : col_eff + 1'b1;

	// Results start once the pixel at row 2, column 2 arrives (2*W+2 lag).
	assign emit = is_pix ? ((row_eff > RW'(2)) || ((row_eff == RW'(2)) && (col_eff >= CW'(2))))
	                     : drain_emit;

	// The mark computed for this beat belongs to the pixel one row up and
	// one column left; it is interior only from row 2 and column 2 on and
	// never past the frame end.
	assign interior = is_pix && (col_eff >= CW'(2)) && (row_eff >= RW'(2));

	// Ready looks at the queue and the results still in the pipeline only.
	assign occ = rq_stat.count + RQ_CNT_W'(v_s1 & emit_s1) + RQ_CNT_W'(v_s2 & emit_s2);
	assign pixels.ready = (occ < RQ_CNT_W'(RQ_DEPTH));

	// ------------------------------------------------------------------
	// Control state.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_col_q   <= CW'(RST_W - 1);
			last_row_q   <= RW'(RST_H - 1);
			in_col_q     <= '0;
			in_row_q     <= '0;
			frame_done_q <= 1'b0;
			out_col_q    <= '0;
			out_row_q    <= '0;
			out_done_q   <= 1'b0;
			v_s1         <= 1'b0;
			emit_s1      <= 1'b0;
			v_s2         <= 1'b0;
			emit_s2      <= 1'b0;
		end else begin
			v_s1    <= issue;
			emit_s1 <= issue && emit;
			v_s2    <= v_s1;
			emit_s2 <= v_s1 && emit_s1;

			if (cfg_wr_en) begin
				unique case (cfg_reg_t'(cfg_index))
					REG_IMAGE_WIDTH:  last_col_q <= cfg_last_col;
					REG_IMAGE_HEIGHT: last_row_q <= cfg_last_row;
				endcase
				in_col_q     <= '0;
				in_row_q     <= '0;
				frame_done_q <= 1'b0;
				out_col_q    <= '0;
				out_row_q    <= '0;
				out_done_q   <= 1'b0;
			end else if (issue) begin
				in_col_q <= col_nxt;
				if (is_pix) begin
					if (col_eff == last_col_q) begin
						if (row_eff == last_row_q) begin
							in_row_q     <= '0;
							frame_done_q <= 1'b1;
						end else begin
							in_row_q     <= row_eff + 1'b1;
							frame_done_q <= 1'b0;
						end
					end else begin
						in_row_q     <= row_eff;
						frame_done_q <= 1'b0;
					end
				end

				if (emit) begin
					out_done_q <= out_last;
					if (out_col_eff == last_col_q) begin
						out_col_q <= '0;
						out_row_q <= out_last ? out_row_eff : out_row_eff + 1'b1;
					end else begin
						out_col_q <= out_col_eff + 1'b1;
						out_row_q <= out_row_eff;
					end
				end else begin
					out_col_q  <= out_col_eff;
					out_row_q  <= out_row_eff;
					out_done_q <= restart ? 1'b0 : out_done_q;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage 1. The source memory is read at the accepting edge and written
	// back in the cycle after. The same column comes back only after W >= 3
	// beats, so a read never meets a pending write to its own entry.
	// Column vectors are {row i, row i-1, row i-2}.
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (issue) begin
			src_rd_s1 <= src_mem[col_eff];
			pix_s1    <= is_pix & pixels.pixel_bit;
			col_s1    <= col_eff;
			inter_s1  <= interior;
			res_s1    <= '{edge_bit: 1'b0,
			               out_row: COORD_W'(out_row_eff),
			               out_col: COORD_W'(out_col_eff),
			               frame_last: out_last};
		end
		if (v_s1) begin
			src_mem[col_s1] <= {src_rd_s1[0], pix_s1};
		end
	end

	assign col_v = {pix_s1, src_rd_s1[0], src_rd_s1[1]};

	// The window center is the middle of the previous column.
	assign nb_l   = sw2_q[1];
	assign nb_r   = col_v[1];
	assign nb_t   = sw1_q[0];
	assign nb_b   = sw1_q[2];
	assign nb_sum = {2'b00, nb_l} + {2'b00, nb_r} + {2'b00, nb_t} + {2'b00, nb_b};

	// One set neighbor, or two that form an L rather than a straight pair.
	assign mark_c = inter_s1 && !sw1_q[1] &&
		((nb_sum == 3'd1) || ((nb_sum == 3'd2) && !(nb_l && nb_r) && !(nb_t && nb_b)));

	always_ff @(posedge clk) begin
		if (v_s1) begin
			sw2_q   <= sw1_q;
			sw1_q   <= col_v;
			mrd_s2  <= mark_mem[col_s1];
			pair_s2 <= {sw1_q[1], mark_c};
			col_s2  <= col_s1;
			res_s2  <= res_s1;
		end
		if (v_s2) begin
			mark_mem[col_s2] <= {mrd_s2[1:0], pair_s2};
		end
	end

	// ------------------------------------------------------------------
	// Stage 2. Columns of {source, mark} pairs, newest row in the top bits.
	// The edge keeps its mark only when the 3x3 mark count differs from
	// the 3x3 source count around it.
	// ------------------------------------------------------------------
	assign col2_v   = {pair_s2, mrd_s2[1:0], mrd_s2[3:2]};
	assign mwin     = {col2_v, mw1_q, mw2_q};
	assign mark_sum = count_bits(mwin, 1'b0);
	assign src_sum  = count_bits(mwin, 1'b1);
	assign edge_c   = mw1_q[2] && (mark_sum != src_sum);

	always_ff @(posedge clk) begin
		if (v_s2) begin
			mw2_q <= mw1_q;
			mw1_q <= col2_v;
		end
	end

	always_comb begin
		push_data          = res_s2;
		push_data.edge_bit = edge_c;
	end

	assign push = v_s2 && emit_s2;
	assign pop  = results.valid && results.ready;

	biem_result_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.stat      (rq_stat)
	);

	assign results.valid      = !rq_stat.empty;
	assign results.edge_bit   = head.edge_bit;
	assign results.out_row    = head.out_row;
	assign results.out_col    = head.out_col;
	assign results.frame_last = head.frame_last;

	// ------------------------------------------------------------------
	// Checks.
	// ------------------------------------------------------------------
	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !rq_stat.full)
		else $error("result pushed into a full queue");

	a_credit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ <= RQ_CNT_W'(RQ_DEPTH))
		else $error("queued plus in-flight results exceed queue depth");

	a_drain_unmarked: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && pixels.command && drain_emit) |=> (v_s1 && emit_s1 && !inter_s1))
		else $error("drain beat entered the pipeline as an interior pixel");

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for binary_image_edge_marker_core
// Streams binary frames of many sizes through the pixel channel, predicts
// each edge mark with a behavioral line-ring model, and compares every
// result beat field by field while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top import biem_pkg::*; ();

	localparam int MAX_W          = 1024;
	localparam int MAX_H          = 1024;
	localparam int RING_ROWS      = 5;
	localparam int RANDOM_BEATS   = 660;
	localparam int SETTLE_CYCLES  = 8;
	localparam int HOLD_CYCLES    = 400;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int REPORT_LIMIT   = 40;

	// Operation carried by a pixel channel beat.
	typedef enum logic {
		CMD_PIXEL = 1'b0,
		CMD_DRAIN = 1'b1
	} beat_cmd_t;

	// A beat waiting to be offered, with the idle cycles that precede it.
	typedef struct {
		beat_cmd_t   command;
		bit          pixel_bit;
		int unsigned gap;
	} pixel_beat_t;

	logic             clk;
	logic             arst_n;
	logic             cfg_wr_en = 1'b0;
	cfg_reg_t         cfg_index = REG_IMAGE_WIDTH;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	biem_pixel_if  pix ();
	biem_result_if res ();

	binary_image_edge_marker_core #(
		.MAX_WIDTH  (MAX_W),
		.MAX_HEIGHT (MAX_H)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.pixels    (pix),
		.results   (res)
	);

	// Beats not yet offered, and marks predicted but not yet seen.
	pixel_beat_t pending_beats[$];
	result_t     expected_marks[$];

	// Shadow of the block: raw register values, the source line ring, the
	// input raster position and the raster index of the next result.
	logic [CFG_DATA_W-1:0] width_reg  = CFG_DATA_W'(DIM_RESET_WIDTH);
	logic [CFG_DATA_W-1:0] height_reg = CFG_DATA_W'(DIM_RESET_HEIGHT);
	bit          src_ring [RING_ROWS][MAX_W];
	int unsigned in_row;
	int unsigned in_col;
	int unsigned mark_pos;
	bit          frame_complete;

	// Run statistics.
	int unsigned beats_queued;
	int unsigned pixel_beats_taken;
	int unsigned drain_beats_taken;
	int unsigned marks_checked;
	int unsigned edges_seen;
	int unsigned reg_writes;
	int unsigned mismatch_count;

	// Receiver pacing.
	logic        hold_req = 1'b0;
	int unsigned hold_left;
	int unsigned stall_left;
	int unsigned sink_roll;
	bit          sink_calm;
	int unsigned quiet_cycles;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// Edge mark predictor
	// ------------------------------------------------------------------------

	// Registers hold 11 bits; the block uses them clamped to 3..MAX.
	function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
		if (v < 3) return 3;
		if (v > hi) return hi;
		return v;
	endfunction

	function automatic int unsigned active_w();
		return clamp_dim(width_reg, MAX_W);
	endfunction

	function automatic int unsigned active_h();
		return clamp_dim(height_reg, MAX_H);
	endfunction

	function automatic void restart_frame();
		in_row         = 0;
		in_col         = 0;
		mark_pos       = 0;
		frame_complete = 1'b0;
	endfunction

	function automatic int src_at(int r, int c);
		return int'(src_ring[r % RING_ROWS][c]);
	endfunction

	// First window stage: a 0-pixel off the border is a candidate when it
	// has one set 4-neighbor, or two that meet at a corner.
	function automatic int mark_at(int r, int c, int w, int h);
		int lr;
		int tb;
		if (r < 1 || r + 1 >= h || c < 1 || c + 1 >= w) return 0;
		if (src_at(r, c) != 0) return 0;
		lr = src_at(r, c - 1) + src_at(r, c + 1);
		tb = src_at(r - 1, c) + src_at(r + 1, c);
		if (lr + tb == 1) return 1;
		if (lr + tb == 2 && lr != 2 && tb != 2) return 1;
		return 0;
	endfunction

	// Second window stage: a candidate survives unless its 3x3 mark count
	// equals its 3x3 count of set source pixels.
	function automatic bit edge_at(int r, int c, int w, int h);
		int marks;
		int ones;
		int dr;
		int dc;
		if (mark_at(r, c, w, h) == 0) return 1'b0;
		marks = 0;
		ones  = 0;
		for (dr = -1; dr <= 1; dr++) begin
			for (dc = -1; dc <= 1; dc++) begin
				marks += mark_at(r + dr, c + dc, w, h);
				ones  += src_at(r + dr, c + dc);
			end
		end
		return marks != ones;
	endfunction

	// Applies one accepted beat to the shadow state and queues the result
	// it releases, if any. Results trail the input by two rows and two
	// pixels; drains release the tail once the whole frame is in.
	task automatic predict_beat(input beat_cmd_t cmd, input bit px);
		int unsigned w;
		int unsigned h;
		int unsigned total;
		int unsigned lag;
		int unsigned p;
		int unsigned r;
		int unsigned c;
		bit          emit;
		result_t     m;
		w     = active_w();
		h     = active_h();
		total = w * h;
		lag   = 2 * w + 2;
		if (cmd == CMD_PIXEL) begin
			pixel_beats_taken++;
			if (frame_complete) restart_frame();
			if (in_row >= h || in_col >= w) begin
				in_row = 0;
				in_col = 0;
			end
			src_ring[in_row % RING_ROWS][in_col] = px;
			p = in_row * w + in_col;
			in_col++;
			if (in_col == w) begin
				in_col = 0;
				in_row++;
				if (in_row == h) begin
					in_row         = 0;
					frame_complete = 1'b1;
				end
			end
			emit = mark_pos < total && mark_pos + lag <= p;
		end else begin
			drain_beats_taken++;
			emit = frame_complete && mark_pos < total;
		end
		if (emit) begin
			r            = mark_pos / w;
			c            = mark_pos % w;
			m.edge_bit   = edge_at(r, c, w, h);
			m.out_row    = COORD_W'(r);
			m.out_col    = COORD_W'(c);
			m.frame_last = (mark_pos + 1 == total);
			expected_marks.push_back(m);
			mark_pos++;
		end
	endtask

	// ------------------------------------------------------------------------
	// Checking
	// ------------------------------------------------------------------------

	task automatic report_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= REPORT_LIMIT) $display("MISMATCH at %0t ns: %s", $time, msg);
	endtask

	task automatic check_field(input string name, input int unsigned got,
			input int unsigned want, input result_t ref_mark);
		if (got != want) begin
			report_mismatch($sformatf("%s got %0d, expected %0d (row %0d col %0d)",
				name, got, want, ref_mark.out_row, ref_mark.out_col));
		end
	endtask

	// Compares one accepted result beat with the oldest prediction.
	task automatic check_result_beat();
		result_t want;
		if (expected_marks.size() == 0) begin
			report_mismatch($sformatf("result with nothing predicted: row %0d col %0d",
				res.out_row, res.out_col));
			return;
		end
		want = expected_marks.pop_front();
		marks_checked++;
		if (want.edge_bit) edges_seen++;
		check_field("edge_bit", res.edge_bit, want.edge_bit, want);
		check_field("out_row", res.out_row, want.out_row, want);
		check_field("out_col", res.out_col, want.out_col, want);
		check_field("frame_last", res.frame_last, want.frame_last, want);
	endtask

	// ------------------------------------------------------------------------
	// Pixel channel driver
	// ------------------------------------------------------------------------

	// A beat in flight is held until the block takes it. Each queued beat
	// carries its own leading idle count, so bursts and gaps are decided
	// when the stimulus is built. The accepted beat is fed to the predictor
	// at the same edge that the block takes it.
	always @(posedge clk or negedge arst_n) begin
		pixel_beat_t nb;
		if (!arst_n) begin
			pix.valid     <= 1'b0;
			pix.command   <= CMD_PIXEL;
			pix.pixel_bit <= 1'b0;
		end else begin
			if (pix.valid && pix.ready) predict_beat(beat_cmd_t'(pix.command), pix.pixel_bit);
			if (!pix.valid || pix.ready) begin
				if (pending_beats.size() == 0) begin
					pix.valid <= 1'b0;
				end else if (pending_beats[0].gap != 0) begin
					pending_beats[0].gap = pending_beats[0].gap - 1;
					pix.valid <= 1'b0;
				end else begin
					nb = pending_beats.pop_front();
					pix.valid     <= 1'b1;
					pix.command   <= nb.command;
					pix.pixel_bit <= nb.pixel_bit;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Result channel monitor
	// ------------------------------------------------------------------------

	// The receiver mixes short stalls with an occasional long one, flips now
	// and then into a calm mode that takes every beat, and drops ready for
	// the whole of a requested hold-off.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res.ready  <= 1'b0;
			stall_left = 0;
			sink_calm  = 1'b0;
		end else begin
			if (res.valid && res.ready) check_result_beat();
			if ($urandom_range(0, 299) == 0) sink_calm = !sink_calm;
			if (hold_left != 0) begin
				res.ready <= 1'b0;
			end else if (stall_left != 0) begin
				stall_left--;
				res.ready <= 1'b0;
			end else if (sink_calm) begin
				res.ready <= 1'b1;
			end else begin
				sink_roll = $urandom_range(0, 99);
				if (sink_roll < 70) begin
					res.ready <= 1'b1;
				end else begin
					stall_left = (sink_roll < 96) ? $urandom_range(0, 2) : $urandom_range(8, 40);
					res.ready <= 1'b0;
				end
			end
		end
	end

	// Long receiver hold-off, counted here in cycles. While it runs the
	// sender keeps offering, so the result queue fills and the block has to
	// push back on the pixel channel.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
		end else if (hold_req) begin
			hold_left <= HOLD_CYCLES;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// Watchdog: the run is hung if no beat moves on either channel for a
	// long time. The longest legal quiet stretch is the hold-off plus one
	// long sender gap and the pause around a register write.
	always @(posedge clk) begin
		if (!arst_n || (pix.valid && pix.ready) || (res.valid && res.ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("Watchdog: no beat accepted for %0d cycles", WATCHDOG_LIMIT);
			$display("Simulation FAILED");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------------

	// Mostly back-to-back beats, some short gaps and a few long ones.
	function automatic int unsigned pick_gap(input bit calm);
		int unsigned roll;
		if (calm) return 0;
		roll = $urandom_range(0, 99);
		if (roll < 60) return 0;
		if (roll < 93) return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	task automatic queue_beat(input beat_cmd_t cmd, input bit px, input bit calm);
		pixel_beat_t b;
		b.command   = cmd;
		b.pixel_bit = px;
		b.gap       = pick_gap(calm);
		pending_beats.push_back(b);
		beats_queued++;
	endtask

	// A raster frame (or its first n pixels) with set pixels at the given
	// density. A stray drain now and then lands mid-frame, where the block
	// has to ignore it.
	task automatic queue_frame(input int unsigned w, input int unsigned h,
			input int unsigned density, input bit calm, input int unsigned n);
		int unsigned i;
		for (i = 0; i < w * h && i < n; i++) begin
			if ($urandom_range(0, 59) == 0) queue_beat(CMD_DRAIN, 1'($urandom_range(0, 1)), calm);
			queue_beat(CMD_PIXEL, $urandom_range(0, 99) < density, calm);
		end
	endtask

	task automatic queue_drains(input int unsigned n, input bit calm);
		int unsigned i;
		for (i = 0; i < n; i++) queue_beat(CMD_DRAIN, 1'($urandom_range(0, 1)), calm);
	endtask

	// Directed rows of a 3-wide frame, given as a bit string read left to
	// right.
	task automatic queue_row3(input bit [2:0] row);
		queue_beat(CMD_PIXEL, row[2], 1'b0);
		queue_beat(CMD_PIXEL, row[1], 1'b0);
		queue_beat(CMD_PIXEL, row[0], 1'b0);
	endtask

	// Waits until every beat has gone in and every predicted result has
	// come out, then lets the pipeline settle in case the last beats were
	// ones that release nothing.
	task automatic wait_idle();
		while (pending_beats.size() != 0 || pix.valid || expected_marks.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Register write; only issued while the block is idle, so the shadow
	// copy can be updated at once. Any write restarts the frame.
	task automatic write_dim(input cfg_reg_t idx, input int unsigned value);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= CFG_DATA_W'(value);
		if (idx == REG_IMAGE_WIDTH) width_reg = CFG_DATA_W'(value);
		else height_reg = CFG_DATA_W'(value);
		restart_frame();
		reg_writes++;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic pulse_hold();
		@(posedge clk);
		hold_req <= 1'b1;
		@(posedge clk);
		hold_req <= 1'b0;
	endtask

	// Mostly in-range sizes, sometimes a value below three that must clamp.
	function automatic int unsigned pick_dim(input int unsigned hi);
		if ($urandom_range(0, 9) == 0) return $urandom_range(0, 2);
		return $urandom_range(3, hi);
	endfunction

	initial begin
		int unsigned random_start;
		int unsigned round;
		int unsigned w;
		int unsigned h;
		int unsigned lag;
		int unsigned roll;
		bit          calm;
		bit          new_setting;

		restart_frame();
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part on the smallest frame, 3 x 3, where only the center
		// pixel is interior and the lag is eight beats.
		write_dim(REG_IMAGE_WIDTH, 3);
		write_dim(REG_IMAGE_HEIGHT, 3);

		// Center sees its top and left neighbors set: a corner pair, so it
		// is a candidate; the far corner is set too, so the source count
		// exceeds the mark count and the mark stays. A drain in the middle
		// of the frame must do nothing, and two drains after the last
		// result must release nothing.
		queue_row3(3'b010);
		queue_beat(CMD_DRAIN, 1'b1, 1'b0);
		queue_row3(3'b100);
		queue_row3(3'b001);
		queue_drains(8 + 2, 1'b0);

		// Left and right set: an opposite pair, never a candidate. Only part
		// of the tail is drained; the next frame's first pixel drops the rest.
		queue_row3(3'b000);
		queue_row3(3'b101);
		queue_row3(3'b000);
		queue_drains(3, 1'b0);

		// A frame cut short by a register write, which drops what was taken.
		// The written values are below the minimum and clamp to three.
		queue_row3(3'b111);
		queue_beat(CMD_PIXEL, 1'b1, 1'b0);
		wait_idle();
		write_dim(REG_IMAGE_WIDTH, 0);
		write_dim(REG_IMAGE_HEIGHT, 2);

		// Random part: small frames of random size and density. Most are
		// fully drained; some are drained in part or not at all, so the next
		// frame or the next register write has to drop the tail. A few are
		// cut short mid-frame and always followed by a register write.
		random_start = beats_queued;
		round        = 0;
		new_setting  = 1'b1;
		while (beats_queued - random_start < RANDOM_BEATS) begin
			if (new_setting || $urandom_range(0, 2) == 0) begin
				wait_idle();
				write_dim(REG_IMAGE_WIDTH, pick_dim(14));
				write_dim(REG_IMAGE_HEIGHT, pick_dim(9));
			end
			w    = active_w();
			h    = active_h();
			lag  = 2 * w + 2;
			calm = ($urandom_range(0, 3) == 0);
			new_setting = 1'b0;
			if ($urandom_range(0, 11) == 0) begin
				queue_frame(w, h, $urandom_range(0, 4) * 20 + 10, calm,
					$urandom_range(1, w * h - 1));
				new_setting = 1'b1;
			end else begin
				queue_frame(w, h, $urandom_range(0, 4) * 20 + 10, calm, w * h);
				roll = $urandom_range(0, 9);
				if (roll == 0) queue_drains(lag + $urandom_range(1, 3), calm);
				else if (roll < 7) queue_drains(lag, calm);
				else if (roll < 9) queue_drains($urandom_range(0, lag - 1), calm);
			end
			if (round == 4) pulse_hold();
			round++;
		end

		// Widest frame: the width register is written at its top value and
		// clamps to the maximum, the height written as one clamps to three.
		// Only the start of the frame is sent, too early for any result.
		wait_idle();
		write_dim(REG_IMAGE_WIDTH, 2047);
		write_dim(REG_IMAGE_HEIGHT, 1);
		queue_frame(active_w(), active_h(), 30, 1'b0, 40);

		// Tallest frame, with the height register written at the maximum and
		// the frame cut short. The hold-off starts once results are flowing
		// and most of the pixels are still waiting to be offered.
		wait_idle();
		write_dim(REG_IMAGE_WIDTH, 3);
		write_dim(REG_IMAGE_HEIGHT, 1024);
		queue_frame(active_w(), active_h(), 40, 1'b0, 240);
		while (pending_beats.size() > 160) @(posedge clk);
		pulse_hold();

		wait_idle();
		repeat (20) @(posedge clk);

		$display("Run covered %0d pixel beats and %0d drain beats over %0d register writes,",
			pixel_beats_taken, drain_beats_taken, reg_writes);
		$display("with %0d result beats checked, %0d of them marked as edge pixels.",
			marks_checked, edges_seen);
		if (mismatch_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
